// ----- sv/hmf_pkg.sv -----
// hmf_pkg: shared constants, types and codes of the histogram median filter
// depends on nothing; imported by every module of the block except hmf_ram
`timescale 1ns / 1ps

package hmf_pkg;

  // frame and kernel limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_RADIUS = 7;
  localparam int SLOTS      = 2 * MAX_RADIUS + 1;
  localparam int LEVELS     = 256;
  localparam int HEIGHT_CAP = 1024;

  // widths
  localparam int PIX_W      = 8;
  localparam int CNT_W      = 8;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int RS_DEPTH   = SLOTS * MAX_WIDTH;
  localparam int RS_AW      = $clog2(RS_DEPTH);
  localparam int RAD_W      = 3;
  localparam int DIM_W      = 11;
  localparam int K_W        = $clog2(SLOTS + 1);
  localparam int THR_W      = $clog2(SLOTS * SLOTS + 1);
  localparam int SUM_W      = CNT_W + 1;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 11;

  // register indexes of the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_RADIUS = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT = 2'd2;

  // register reset values
  localparam logic [RAD_W-1:0] RADIUS_RST = 3'd1;
  localparam logic [DIM_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd480;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD_RD,
    ST_UPD_WT,
    ST_SCAN_GO,
    ST_SCAN_WT,
    ST_FIN
  } hmf_state_t;

  // requests to the window histogram unit
  typedef struct packed {
    logic             clear;
    logic             upd;
    logic             dec;
    logic [PIX_W-1:0] bin;
    logic             scan;
    logic [THR_W-1:0] thr;
  } hmf_win_cmd_t;

  // answer of the window histogram unit
  typedef struct packed {
    logic             done;
    logic [PIX_W-1:0] median;
  } hmf_win_rsp_t;

endpackage

// ----- sv/hmf_ram.sv -----
// hmf_ram: generic simple dual-port RAM, one write port and one registered read port
// depends on nothing
`timescale 1ns / 1ps

module hmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/hmf_win.sv -----
// hmf_win: window histogram in a RAM with per-bin valid bits, bin update and median scan
// depends on hmf_pkg and hmf_ram
`timescale 1ns / 1ps

module hmf_win (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hmf_pkg::hmf_win_cmd_t cmd,
  output hmf_pkg::hmf_win_rsp_t rsp
);
  import hmf_pkg::*;

  logic [LEVELS-1:0] valid_r;
  logic              wr_pend_r;
  logic [PIX_W-1:0]  wr_bin_r;
  logic              wr_dec_r;
  logic              scanning_r;
  logic [PIX_W-1:0]  scan_addr_r;
  logic              chk_r;
  logic [PIX_W-1:0]  chk_bin_r;
  logic [SUM_W-1:0]  cum_r;
  logic [THR_W-1:0]  thr_r;
  logic              done_r;
  logic [PIX_W-1:0]  median_r;

  logic [PIX_W-1:0]  raddr;
  logic [CNT_W-1:0]  rdata;
  logic [CNT_W-1:0]  wr_cnt;
  logic [CNT_W-1:0]  wdata;
  logic [CNT_W-1:0]  chk_cnt;
  logic [SUM_W-1:0]  cum_sum;
  logic              hit;

  // read address: update request or scan pointer
  assign raddr = cmd.upd ? cmd.bin : scan_addr_r;

  // modify stage of a bin update, an invalid bin counts as zero
  assign wr_cnt = valid_r[wr_bin_r] ? rdata : '0;
  assign wdata  = wr_dec_r ? wr_cnt - CNT_W'(1) : wr_cnt + CNT_W'(1);

  hmf_ram #(
    .WIDTH(CNT_W),
    .DEPTH(LEVELS)
  ) u_win_ram (
    .clk  (clk),
    .we   (wr_pend_r),
    .waddr(wr_bin_r),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // check stage of the scan
  assign chk_cnt = valid_r[chk_bin_r] ? rdata : '0;
  assign cum_sum = cum_r + SUM_W'(chk_cnt);
  assign hit     = chk_r && ((cum_sum >= SUM_W'(thr_r)) || (chk_bin_r == PIX_W'(LEVELS - 1)));

  // valid bits, clear wins over a late write of the previous window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.clear) begin
      valid_r <= '0;
    end else if (wr_pend_r) begin
      valid_r[wr_bin_r] <= 1'b1;
    end
  end

  // pending write of a bin update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pend_r <= 1'b0;
    end else begin
      wr_pend_r <= cmd.upd;
    end
    if (cmd.upd) begin
      wr_bin_r <= cmd.bin;
      wr_dec_r <= cmd.dec;
    end
  end

  // scan control: one bin read a cycle, stop on the first hit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scanning_r <= 1'b0;
      chk_r      <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      done_r <= hit;
      if (cmd.scan) begin
        scanning_r <= 1'b1;
        chk_r      <= 1'b0;
      end else if (hit) begin
        scanning_r <= 1'b0;
        chk_r      <= 1'b0;
      end else begin
        chk_r <= scanning_r;
        if (scanning_r && (scan_addr_r == PIX_W'(LEVELS - 1))) begin
          scanning_r <= 1'b0;
        end
      end
    end
  end

  // scan data path
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      scan_addr_r <= '0;
      cum_r       <= '0;
      thr_r       <= cmd.thr;
    end else begin
      if (scanning_r) begin
        scan_addr_r <= scan_addr_r + PIX_W'(1);
        chk_bin_r   <= scan_addr_r;
      end
      if (chk_r) begin
        cum_r <= cum_sum;
      end
    end
    if (hit) begin
      median_r <= chk_bin_r;
    end
  end

  assign rsp.done   = done_r;
  assign rsp.median = median_r;

endmodule

// ----- sv/histogram_median_filter_core.sv -----
// histogram_median_filter_core: top level, pixel position, row store and sequencer
// depends on hmf_pkg, hmf_ram and hmf_win
`timescale 1ns / 1ps

// Square median filter over an 8-bit raster pixel stream, window side 2r+1 with r up
// to 7. Only interior positions give a result, tagged with row and column of the
// window centre; border pixels are left to the consumer. A pixel in the first 2r rows
// is only written to the row store and does not stall the input. Any other pixel walks
// the newest column (2r+1 row store reads) into the window histogram and the column
// that leaves it out, one pixel at a time through the single row store read port. A
// pixel that gives a result then scans the window histogram RAM one bin a cycle until
// the median level is reached. A result waiting on the output lets the next pixel in,
// but the next result waits in the sequencer and stalls the input. A configuration
// write restarts the frame; no clearing pass is needed after reset or at a frame start.

module histogram_median_filter_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [hmf_pkg::PIX_W-1:0]       in_pixel,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [hmf_pkg::PIX_W-1:0]       out_median,
  output logic [hmf_pkg::COL_W-1:0]       out_row,
  output logic [hmf_pkg::COL_W-1:0]       out_col,
  output logic                            out_last_of_frame,
  input  logic                            cfg_we,
  input  logic [hmf_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [hmf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import hmf_pkg::*;

  // configuration
  logic [RAD_W-1:0]  radius_r;
  logic [DIM_W-1:0]  width_r;
  logic [DIM_W-1:0]  height_r;

  // input position
  logic [COL_W-1:0]  in_row_r;
  logic [COL_W-1:0]  in_col_r;
  logic [SLOT_W-1:0] in_slot_r;

  // latched transaction under work
  logic [COL_W-1:0]  cur_row_r;
  logic [COL_W-1:0]  cur_col_r;
  logic [SLOT_W-1:0] cur_slot_r;
  logic              cur_last_r;
  logic              cur_out_r;

  hmf_state_t        state_r, state_nxt;
  logic [K_W-1:0]    j_r, j_nxt;
  logic              sub_r, sub_nxt;
  logic [PIX_W-1:0]  med_r, med_nxt;

  logic              out_valid_r;
  logic [PIX_W-1:0]  out_median_r;
  logic [COL_W-1:0]  out_row_r;
  logic [COL_W-1:0]  out_col_r;
  logic              out_last_r;
  logic              out_load;

  logic [RAD_W-1:0]  r_eff;
  logic [K_W-1:0]    k_eff;
  logic [K_W-1:0]    two_r;
  logic [DIM_W-1:0]  w_eff;
  logic [DIM_W-1:0]  h_eff;
  logic [THR_W-1:0]  thr;
  logic              in_fire;
  logic              col_last;
  logic              row_last;
  logic              in_work;

  logic [SLOT_W:0]   slot_diff;
  logic [SLOT_W-1:0] rd_slot;
  logic [COL_W-1:0]  rd_col;
  logic [RS_AW-1:0]  rs_waddr;
  logic [RS_AW-1:0]  rs_raddr;
  logic [PIX_W-1:0]  rs_rdata;

  hmf_win_cmd_t      win_cmd;
  hmf_win_rsp_t      win_rsp;

  // effective kernel and frame sizes
  always_comb begin
    r_eff = (radius_r > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_r;
    two_r = K_W'(r_eff) << 1;
    k_eff = two_r + K_W'(1);
    thr   = THR_W'((THR_W'(k_eff) * THR_W'(k_eff) + THR_W'(1)) >> 1);
    if (width_r == '0) begin
      w_eff = DIM_W'(1);
    end else if (width_r > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    if (height_r == '0) begin
      h_eff = DIM_W'(1);
    end else if (height_r > DIM_W'(HEIGHT_CAP)) begin
      h_eff = DIM_W'(HEIGHT_CAP);
    end else begin
      h_eff = height_r;
    end
  end

  // input handshake
  assign in_stall = (state_r != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign col_last = (DIM_W'(in_col_r) == w_eff - DIM_W'(1));
  assign row_last = (DIM_W'(in_row_r) == h_eff - DIM_W'(1));
  assign in_work  = (in_row_r >= COL_W'(two_r));

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_RADIUS: radius_r <= cfg_data[RAD_W-1:0];
        REG_WIDTH:  width_r  <= cfg_data[DIM_W-1:0];
        REG_HEIGHT: height_r <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // raster position and row store slot of the next pixel
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      in_row_r  <= '0;
      in_col_r  <= '0;
      in_slot_r <= '0;
    end else if (in_fire) begin
      if (col_last) begin
        in_col_r <= '0;
        if (row_last) begin
          in_row_r  <= '0;
          in_slot_r <= '0;
        end else begin
          in_row_r  <= in_row_r + COL_W'(1);
          in_slot_r <= (in_slot_r == SLOT_W'(SLOTS - 1)) ? '0 : in_slot_r + SLOT_W'(1);
        end
      end else begin
        in_col_r <= in_col_r + COL_W'(1);
      end
    end
  end

  // latch the accepted transaction
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur_row_r  <= in_row_r;
      cur_col_r  <= in_col_r;
      cur_slot_r <= in_slot_r;
      cur_last_r <= col_last && row_last;
      cur_out_r  <= (in_col_r >= COL_W'(two_r));
    end
  end

  // row store read address: slot j rows up, newest or leaving column
  assign slot_diff = {1'b0, cur_slot_r} - (SLOT_W + 1)'(j_r);
  assign rd_slot   = slot_diff[SLOT_W] ? SLOT_W'(slot_diff + (SLOT_W + 1)'(SLOTS))
                                       : slot_diff[SLOT_W-1:0];
  assign rd_col    = sub_r ? cur_col_r - COL_W'(k_eff) : cur_col_r;
  // MAX_WIDTH is a power of two, so slot and column concatenate
  assign rs_waddr  = {in_slot_r, in_col_r};
  assign rs_raddr  = {rd_slot, rd_col};

  hmf_ram #(
    .WIDTH(PIX_W),
    .DEPTH(RS_DEPTH)
  ) u_row_store (
    .clk  (clk),
    .we   (in_fire),
    .waddr(rs_waddr),
    .wdata(in_pixel),
    .raddr(rs_raddr),
    .rdata(rs_rdata)
  );

  hmf_win u_win (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (win_cmd),
    .rsp  (win_rsp)
  );

  // sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      j_r     <= '0;
      sub_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      j_r     <= j_nxt;
      sub_r   <= sub_nxt;
    end
    med_r <= med_nxt;
  end

  // sequencer next state and window requests
  always_comb begin
    state_nxt   = state_r;
    j_nxt       = j_r;
    sub_nxt     = sub_r;
    med_nxt     = med_r;
    out_load    = 1'b0;
    win_cmd     = '0;
    win_cmd.bin = rs_rdata;
    win_cmd.dec = sub_r;
    win_cmd.thr = thr;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && in_work) begin
          win_cmd.clear = (in_col_r == '0);
          j_nxt         = '0;
          sub_nxt       = 1'b0;
          state_nxt     = ST_UPD_RD;
        end
      end
      ST_UPD_RD: begin
        state_nxt = ST_UPD_WT;
      end
      ST_UPD_WT: begin
        win_cmd.upd = 1'b1;
        if (j_r == two_r) begin
          if (!sub_r && (cur_col_r >= COL_W'(k_eff))) begin
            sub_nxt   = 1'b1;
            j_nxt     = '0;
            state_nxt = ST_UPD_RD;
          end else if (cur_out_r) begin
            state_nxt = ST_SCAN_GO;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          j_nxt     = j_r + K_W'(1);
          state_nxt = ST_UPD_RD;
        end
      end
      ST_SCAN_GO: begin
        win_cmd.scan = 1'b1;
        state_nxt    = ST_SCAN_WT;
      end
      ST_SCAN_WT: begin
        if (win_rsp.done) begin
          med_nxt   = win_rsp.median;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_median_r <= med_r;
      out_row_r    <= cur_row_r - COL_W'(r_eff);
      out_col_r    <= cur_col_r - COL_W'(r_eff);
      out_last_r   <= cur_last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_median        = out_median_r;
  assign out_row           = out_row_r;
  assign out_col           = out_col_r;
  assign out_last_of_frame = out_last_r;

  // a transaction in a window row starts the column walk
  a_work_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_work |=> state_r == ST_UPD_RD)
    else $error("window transaction did not start the column walk");

  // the leaving column exists only from column k on
  a_sub_col: assert property (@(posedge clk) disable iff (!rst_n)
    sub_r && (state_r == ST_UPD_RD || state_r == ST_UPD_WT) |-> cur_col_r >= COL_W'(k_eff))
    else $error("leaving column walked before column k");

  // scan answers arrive only while waiting for them
  a_scan_done: assert property (@(posedge clk) disable iff (!rst_n)
    win_rsp.done |-> state_r == ST_SCAN_WT)
    else $error("median answer outside the scan wait");

  // a result is loaded only into a free or draining output register
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !out_valid_r || !out_stall)
    else $error("result loaded over a pending transaction");

endmodule

// ----- tb/tb.sv -----
// tb: self-checking testbench of histogram_median_filter_core
// depends on hmf_pkg and the filter RTL; predicts every median with its own frame model
`timescale 1ns / 1ps

module tb;
  import hmf_pkg::*;

  localparam int QUIET_LIMIT = 20000;
  localparam int DRAIN_WAIT  = 500;

  // register index beyond the list, restarts the frame and changes nothing else
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic [PIX_W-1:0] median;
    logic [COL_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } median_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [PIX_W-1:0]      in_pixel;
  logic                  out_valid;
  logic                  out_stall;
  logic [PIX_W-1:0]      out_median;
  logic [COL_W-1:0]      out_row;
  logic [COL_W-1:0]      out_col;
  logic                  out_last_of_frame;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;

  histogram_median_filter_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_pixel(in_pixel),
    .out_valid(out_valid), .out_stall(out_stall), .out_median(out_median),
    .out_row(out_row), .out_col(out_col), .out_last_of_frame(out_last_of_frame),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  // frame model state
  logic [PIX_W-1:0] line_mem [SLOTS*MAX_WIDTH];
  logic [15:0]      column_cnt [MAX_WIDTH][LEVELS];
  logic [15:0]      win_hist [LEVELS];
  int               pos_row, pos_col;
  logic [RAD_W-1:0] radius_reg;
  logic [DIM_W-1:0] width_reg, height_reg;

  logic [PIX_W-1:0] pixels_q [$];
  median_result_t   medians_q [$];
  int               fail_count;
  int               quiet_cycles;
  bit               took;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // append one pixel to the pending queue
  task automatic queue_pixel(logic [PIX_W-1:0] pix);
    pixels_q = {pixels_q, pix};
  endtask

  // register write, also moves the model back to the frame start
  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, int val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    case (idx)
      REG_RADIUS: radius_reg = val[RAD_W-1:0];
      REG_WIDTH:  width_reg  = val[DIM_W-1:0];
      REG_HEIGHT: height_reg = val[DIM_W-1:0];
      default: ;
    endcase
    pos_row = 0;
    pos_col = 0;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // one pixel into the frame model; queues the median it yields, if any
  task automatic take_pixel(logic [PIX_W-1:0] pix);
    int r, k, w, h, row, col, v, cum, thr;
    median_result_t res;
    r = (radius_reg > MAX_RADIUS) ? MAX_RADIUS : radius_reg;
    k = 2 * r + 1;
    w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
    h = (height_reg == 0) ? 1 : (height_reg > HEIGHT_CAP ? HEIGHT_CAP : height_reg);
    row = (pos_row >= h) ? 0 : pos_row;
    col = (pos_col >= w) ? 0 : pos_col;
    if (row == 0 && col == 0)
      for (int c = 0; c < w; c++)
        for (int g = 0; g < LEVELS; g++) column_cnt[c][g] = '0;
    // column histogram follows the last k rows
    if (row >= k)
      column_cnt[col][line_mem[((row - k) % SLOTS) * MAX_WIDTH + col]] -= 16'd1;
    line_mem[(row % SLOTS) * MAX_WIDTH + col] = pix;
    column_cnt[col][pix] += 16'd1;
    if (row >= 2 * r) begin
      if (col == 0)
        for (int g = 0; g < LEVELS; g++) win_hist[g] = '0;
      for (int g = 0; g < LEVELS; g++) begin
        v = win_hist[g] + column_cnt[col][g];
        if (col >= k) v -= column_cnt[col - k][g];
        win_hist[g] = v[15:0];
      end
      if (col >= 2 * r) begin
        thr = (k * k + 1) / 2;
        cum = 0;
        res.median = 8'd255;
        for (int g = 0; g < LEVELS; g++) begin
          cum += win_hist[g];
          if (cum >= thr) begin
            res.median = g[PIX_W-1:0];
            break;
          end
        end
        res.row  = COL_W'(row - r);
        res.col  = COL_W'(col - r);
        res.last = (row == h - 1 && col == w - 1);
        medians_q = {medians_q, res};
      end
    end
    col++;
    if (col >= w) begin
      col = 0;
      row++;
      if (row >= h) row = 0;
    end
    pos_row = row;
    pos_col = col;
  endtask

  // accepted transactions on both channels, checks and watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      took <= 1'b0;
    end else begin
      took <= in_valid && !in_stall;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (in_valid && !in_stall) begin
        take_pixel(in_pixel);
        void'(pixels_q.pop_front());
      end
      if (out_valid && !out_stall) begin
        median_result_t exp_res;
        if (medians_q.size() == 0) begin
          report("unexpected result row", out_row, -1);
        end else begin
          exp_res = medians_q.pop_front();
          if (out_median !== exp_res.median) report("median", out_median, exp_res.median);
          if (out_row !== exp_res.row) report("row", out_row, exp_res.row);
          if (out_col !== exp_res.col) report("col", out_col, exp_res.col);
          if (out_last_of_frame !== exp_res.last)
            report("last_of_frame", out_last_of_frame, exp_res.last);
        end
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // sender: bursts with random gaps, payload held while stalled
  int burst_left, gap_left;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !took) begin
        // hold the stalled transaction
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pixels_q.size() > 0) begin
        in_valid <= 1'b1;
        in_pixel <= pixels_q[0];
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern switches between free, random and long holds
  int stall_mode, mode_left;
  always @(negedge clk) begin
    if (rst_n) begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left  <= $urandom_range(20, 400);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 1) == 1);
        default: out_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  task automatic drain();
    wait (pixels_q.size() == 0 && medians_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic setup(int rad, int wid, int hgt);
    drain();
    write_reg(REG_RADIUS, rad);
    write_reg(REG_WIDTH, wid);
    write_reg(REG_HEIGHT, hgt);
  endtask

  // stimulus
  initial begin
    int rad, w, h, n, mode, base, random_items;
    int kk, weff, heff;
    in_valid = 1'b0; in_pixel = '0; out_stall = 1'b0;
    cfg_we = 1'b0; cfg_addr = '0; cfg_data = '0;
    rst_n = 1'b0;
    fail_count = 0; quiet_cycles = 0; took = 1'b0;
    burst_left = 0; gap_left = 0; stall_mode = 0; mode_left = 0;
    radius_reg = RADIUS_RST; width_reg = WIDTH_RST; height_reg = HEIGHT_RST;
    pos_row = 0; pos_col = 0;
    for (int g = 0; g < LEVELS; g++) win_hist[g] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset registers: a few pixels of a 640-wide frame, then a 5x4 frame with extremes
    for (int i = 0; i < 8; i++) queue_pixel(i[0] ? 8'hFF : 8'h00);
    setup(1, 5, 4);
    for (int i = 0; i < 20; i++)
      queue_pixel((i % 3 == 0) ? 8'hFF : (i % 3 == 1) ? 8'h00 : PIX_W'(8'h80 + i));

    // window larger than the frame: radius 7 on 5x5, no results
    setup(7, 5, 5);
    for (int i = 0; i < 25; i++) queue_pixel(PIX_W'($urandom_range(0, 255)));

    // full 15x16 frame at the largest radius, last interior pixel flagged
    setup(7, 15, 16);
    for (int i = 0; i < 240; i++) queue_pixel(PIX_W'($urandom_range(0, 255)));

    // width beyond the limit saturates to a 1024-pixel row, radius 0
    setup(0, 2047, 1);
    for (int i = 0; i < 1026; i++) queue_pixel(PIX_W'($urandom_range(0, 3)));

    // zero dimensions count as one; height beyond the limit
    setup(0, 0, 0);
    for (int i = 0; i < 4; i++) queue_pixel(PIX_W'(8'hA5 ^ i));
    setup(1, 4, 2047);
    for (int i = 0; i < 30; i++) queue_pixel(PIX_W'($urandom_range(0, 255)));
    // unused register index restarts the frame mid-row
    drain();
    write_reg(REG_UNUSED, 11'h555);
    for (int i = 0; i < 20; i++) queue_pixel(PIX_W'($urandom_range(0, 255)));

    // random frames
    random_items = 0;
    while (random_items < 530) begin
      rad = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3);
      kk = 2 * rad + 1;
      w = $urandom_range((kk > 3) ? kk - 2 : 1, kk + 8);
      h = $urandom_range((kk > 3) ? kk - 2 : 1, kk + 6);
      setup(rad, ($urandom_range(0, 15) == 0) ? 0 : w, h);
      weff = (width_reg == 0) ? 1 : width_reg;
      heff = h;
      n = weff * heff * $urandom_range(1, 2) + (($urandom_range(0, 3) == 0) ?
          $urandom_range(1, weff * heff) : 0);
      mode = $urandom_range(0, 2);
      base = $urandom_range(0, 252);
      for (int i = 0; i < n; i++) begin
        case (mode)
          0: queue_pixel(PIX_W'($urandom_range(0, 255)));
          1: queue_pixel(PIX_W'(base + $urandom_range(0, 3)));
          default: queue_pixel(($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF);
        endcase
      end
      random_items += n;
    end

    drain();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
